// ===== sv/mmpc_pkg.sv =====
// Package for the magnetometer pulse counter: widths, register map, state codes.
// No dependencies.
`default_nettype none
package mmpc_pkg;
    localparam int WINDOW_DEPTH = 512;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 16 + FILL_W;
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_HIGH = 2'd0;
    localparam logic [1:0] REG_LOW = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
        logic [15:0] margin;
        logic [15:0] period;
    } cfg_t;
endpackage
`default_nettype wire

// ===== sv/mmpc_if.sv =====
// Valid/ready channel interfaces for samples and reports.
// Depends on nothing.
`default_nettype none
interface mmpc_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    modport source (output valid, mag_x, mag_y, mag_z, input ready);
    modport sink (input valid, mag_x, mag_y, mag_z, output ready);
endinterface

interface mmpc_out_if;
    logic valid;
    logic ready;
    logic [15:0] magnitude;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0] step_count;
    logic [15:0] min_magnitude;
    logic [15:0] max_magnitude;
    logic [15:0] last_swing;
    logic [15:0] mean_magnitude;
    modport source (output valid, magnitude, axis_x, axis_y, axis_z, step_count,
                    min_magnitude, max_magnitude, last_swing, mean_magnitude,
                    input ready);
    modport sink (input valid, magnitude, axis_x, axis_y, axis_z, step_count,
                  min_magnitude, max_magnitude, last_swing, mean_magnitude,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/mmpc_regs.sv =====
// APB configuration registers of the pulse counter.
// Depends on mmpc_pkg.
`default_nettype none
module mmpc_regs
    import mmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);
    cfg_t cfg_reg;
    logic wr;
    assign pready = 1'b1;
    assign cfg = cfg_reg;
    assign wr = psel && penable && pwrite;

    // Write a register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high <= 16'd17000;
            cfg_reg.low <= 16'd3000;
            cfg_reg.margin <= 16'd500;
            cfg_reg.period <= 16'd79;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_HIGH: cfg_reg.high <= pwdata[15:0];
                REG_LOW: cfg_reg.low <= pwdata[15:0];
                REG_MARGIN: cfg_reg.margin <= pwdata[15:0];
                REG_PERIOD: cfg_reg.period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        prdata = 32'd0;
        case (paddr[3:2])
            REG_HIGH: prdata = {16'd0, cfg_reg.high};
            REG_LOW: prdata = {16'd0, cfg_reg.low};
            REG_MARGIN: prdata = {16'd0, cfg_reg.margin};
            REG_PERIOD: prdata = {16'd0, cfg_reg.period};
            default: prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/mmpc_ring.sv =====
// Window memory: one shared address for a write and a registered read.
// Depends on mmpc_pkg.
`default_nettype none
module mmpc_ring
    import mmpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [PTR_W-1:0] addr,
    input  wire logic [15:0]      wdata,
    output logic      [15:0]      rdata
);
    logic [15:0] mem [WINDOW_DEPTH];

    // Read first, then write the same entry
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
        if (we)
            mem[addr] <= wdata;
    end
endmodule
`default_nettype wire

// ===== sv/mmpc_core.sv =====
// Sequencer: squares, bit-serial root, ring update, serial divide, report.
// Depends on mmpc_pkg, mmpc_ring and the channel interfaces.
`default_nettype none
module mmpc_core
    import mmpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cfg_t             cfg,
    mmpc_in_if.sink          s_in,
    mmpc_out_if.source       s_out
);
    state_t state_reg, state_next;
    logic signed [15:0] x_reg, y_reg, z_reg;
    logic [4:0] sq_cnt_reg, sq_cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [33:0] root_v_reg, root_v_next;
    logic [33:0] root_reg, root_next;
    logic [15:0] mag_reg;
    logic [4:0] it_reg, it_next;
    logic [15:0] lat_reg, min_reg, max_reg, swing_reg, steps_reg, cnt_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [FILL_W:0] drem_reg, drem_next;
    logic [15:0] ring_rd;
    logic ring_we;
    logic out_valid_reg;
    logic [15:0] o_mag_reg, o_steps_reg, o_min_reg, o_max_reg, o_swing_reg, o_mean_reg;
    logic signed [15:0] o_x_reg, o_y_reg, o_z_reg;
    logic [16:0] ax, ay, az;
    logic [33:0] total;
    logic [33:0] trial;
    logic [FILL_W:0] dtrial;
    logic [SUM_W-1:0] win_sum_new;
    logic out_step;

    // Absolute values of the held axes; their squares are summed as the radicand
    assign ax = x_reg[15] ? 17'(-$signed({x_reg[15], x_reg})) : {1'b0, x_reg};
    assign ay = y_reg[15] ? 17'(-$signed({y_reg[15], y_reg})) : {1'b0, y_reg};
    assign az = z_reg[15] ? 17'(-$signed({z_reg[15], z_reg})) : {1'b0, z_reg};

    mmpc_ring u_ring (
        .clk(clk), .we(ring_we), .addr(ptr_reg), .wdata(mag_reg), .rdata(ring_rd)
    );

    // Update step may run unless a report is due and the last one is still held
    assign out_step = (state_reg == ST_OUT)
                      && (cnt_reg != 16'd0 || !out_valid_reg || s_out.ready);

    assign s_in.ready = (state_reg == ST_IDLE);
    assign s_out.valid = out_valid_reg;
    assign s_out.magnitude = o_mag_reg;
    assign s_out.axis_x = o_x_reg;
    assign s_out.axis_y = o_y_reg;
    assign s_out.axis_z = o_z_reg;
    assign s_out.step_count = o_steps_reg;
    assign s_out.min_magnitude = o_min_reg;
    assign s_out.max_magnitude = o_max_reg;
    assign s_out.last_swing = o_swing_reg;
    assign s_out.mean_magnitude = o_mean_reg;

    // Next state and datapath steps
    always_comb
    begin
        state_next = state_reg;
        sq_cnt_next = sq_cnt_reg;
        rem_next = rem_reg;
        root_v_next = root_v_reg;
        root_next = root_reg;
        it_next = it_reg;
        quo_next = quo_reg;
        drem_next = drem_reg;
        ring_we = 1'b0;
        total = 34'd0;
        trial = root_reg + root_v_reg;
        dtrial = {drem_reg[FILL_W-1:0], quo_reg[SUM_W-1]} - {1'b0, fill_reg};
        // window sum with the new magnitude in and, once full, the oldest out
        win_sum_new = sum_reg + SUM_W'(mag_reg);
        if (fill_reg >= FILL_W'(WINDOW_DEPTH))
            win_sum_new = win_sum_new - SUM_W'(ring_rd);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_in.valid && s_in.ready)
                begin
                    state_next = ST_SQ;
                    sq_cnt_next = 5'd0;
                end
            end
            ST_SQ:
            begin
                // one square per cycle
                case (sq_cnt_reg)
                    5'd0: total = 34'(ax * ax);
                    5'd1: total = rem_reg + 34'(ay * ay);
                    default: total = rem_reg + 34'(az * az);
                endcase
                rem_next = total;
                sq_cnt_next = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'd2)
                begin
                    state_next = ST_ROOT;
                    root_v_next = 34'h1 << 32;
                    root_next = 34'd0;
                    it_next = 5'd0;
                end
            end
            ST_ROOT:
            begin
                // one result bit per cycle
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    root_next = (root_reg >> 1) + root_v_reg;
                end
                else
                    root_next = root_reg >> 1;
                root_v_next = root_v_reg >> 2;
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd16)
                begin
                    state_next = ST_READ;
                    it_next = 5'd0;
                end
            end
            ST_READ:
                state_next = ST_DIV;
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (it_reg == 5'd0)
                begin
                    ring_we = 1'b1;
                    quo_next = win_sum_new;
                    drem_next = '0;
                end
                else
                begin
                    if (!dtrial[FILL_W])
                    begin
                        drem_next = dtrial;
                        quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = {drem_reg[FILL_W-1:0], quo_reg[SUM_W-1]};
                        quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                    end
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'(SUM_W))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // when a report is due, hold until the previous report has left
                if (out_step)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath and accumulated state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= 16'd0;
            min_reg <= 16'hFFFF;
            max_reg <= 16'd0;
            swing_reg <= 16'd0;
            steps_reg <= 16'd0;
            cnt_reg <= 16'd0;
            ptr_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_cnt_reg <= sq_cnt_next;
            rem_reg <= rem_next;
            root_v_reg <= root_v_next;
            root_reg <= root_next;
            it_reg <= it_next;
            quo_reg <= quo_next;
            drem_reg <= drem_next;
            if (s_out.valid && s_out.ready && !(out_step && cnt_reg == 16'd0))
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && s_in.valid && s_in.ready)
            begin
                x_reg <= s_in.mag_x;
                y_reg <= s_in.mag_y;
                z_reg <= s_in.mag_z;
            end
            if (state_reg == ST_ROOT && it_reg == 5'd16)
                mag_reg <= root_next[15:0];
            if (state_reg == ST_DIV && it_reg == 5'd0)
            begin
                // ring update with the old entry now read
                sum_reg <= win_sum_new;
                if (fill_reg < FILL_W'(WINDOW_DEPTH))
                    fill_reg <= fill_reg + FILL_W'(1);
                ptr_reg <= (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
            end
            if (out_step)
            begin
                logic [15:0] lat, sw, st;
                lat = lat_reg;
                sw = swing_reg;
                st = steps_reg;
                if (mag_reg < min_reg)
                    min_reg <= mag_reg;
                if (mag_reg > max_reg)
                    max_reg <= mag_reg;
                if (mag_reg > cfg.high && lat < cfg.high)
                begin
                    sw = mag_reg - lat;
                    lat = mag_reg;
                end
                if (mag_reg < cfg.low && {1'b0, lat} > ({1'b0, cfg.low} + {1'b0, cfg.margin}))
                begin
                    if (st != 16'hFFFF)
                        st = st + 16'd1;
                    sw = lat - mag_reg;
                    lat = mag_reg;
                end
                lat_reg <= lat;
                swing_reg <= sw;
                if (cnt_reg == 16'd0)
                begin
                    out_valid_reg <= 1'b1;
                    o_mag_reg <= mag_reg;
                    o_x_reg <= x_reg;
                    o_y_reg <= y_reg;
                    o_z_reg <= z_reg;
                    o_steps_reg <= st;
                    o_min_reg <= (mag_reg < min_reg) ? mag_reg : min_reg;
                    o_max_reg <= (mag_reg > max_reg) ? mag_reg : max_reg;
                    o_swing_reg <= sw;
                    o_mean_reg <= quo_reg[15:0];
                    steps_reg <= 16'd0;
                end
                else
                    steps_reg <= st;
                cnt_reg <= (cnt_reg == cfg.period) ? 16'd0 : cnt_reg + 16'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/magnetometer_meter_pulse_counter_unit.sv =====
// From sample beat to report valid a sample passes the square, root, memory read,
// divide and update steps; one sample at a time, a new sample accepted only in idle.
// A report still waiting holds only the update step of the next reporting sample.
// Reset clears the step and sample counters, extremes and the latch; the fill count keeps unwritten
// window entries out of the mean, so the window memory needs no clearing.
`default_nettype none
module magnetometer_meter_pulse_counter_unit
    import mmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    mmpc_in_if.sink                s_in,
    mmpc_out_if.source             s_out
);
    cfg_t cfg;

    mmpc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    mmpc_core u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .s_in(s_in), .s_out(s_out)
    );
endmodule
`default_nettype wire

// ===== sv/mmpc_checker.sv =====
// Port-level checks on the pulse counter, bound to the top level.
// Depends on the top level and its channel interfaces.
`default_nettype none
module mmpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] min_magnitude,
    input wire logic [15:0] max_magnitude,
    input wire logic [15:0] magnitude
);
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(magnitude))
        else $error("report changed while waiting");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("second sample taken");
    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_magnitude <= magnitude && magnitude <= max_magnitude))
        else $error("extremes do not bound magnitude");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("report dropped");
endmodule

bind magnetometer_meter_pulse_counter_unit mmpc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(s_out.valid), .out_ready(s_out.ready),
    .min_magnitude(s_out.min_magnitude), .max_magnitude(s_out.max_magnitude),
    .magnitude(s_out.magnitude)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for the magnetometer pulse counter: drives samples and
// register writes, predicts reports and compares them. Depends on mmpc_pkg and mmpc_if.
`default_nettype none
module testbench;
    import mmpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } sample_t;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [15:0] steps;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] swing;
        logic [15:0] mean;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mmpc_in_if s_in ();
    mmpc_out_if s_out ();

    magnetometer_meter_pulse_counter_unit uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_in(s_in.sink), .s_out(s_out.source)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [15:0] p_high, p_low, p_margin, p_period;
    logic [15:0] latch_lvl, min_mag, max_mag, swing_val, steps, sample_cnt;
    logic [15:0] ring [WINDOW_DEPTH];
    int unsigned ring_ptr, ring_cnt;
    logic [31:0] win_sum;

    sample_t pending_samples[$];
    report_t expected_reports[$];
    int errors = 0;
    int sent = 0;
    bit no_idle = 1'b0;
    bit hold_off = 1'b0;

    function automatic logic [31:0] square_axis(logic signed [15:0] a);
        logic [31:0] m;
        m = a[15] ? 32'(-32'(a)) : 32'(a);
        return m * m;
    endfunction

    function automatic logic [15:0] isqrt(logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            logic [31:0] t;
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= 64'(v))
                r = t;
        end
        return r[15:0];
    endfunction

    task automatic predict_sample(sample_t s);
        logic [15:0] mag;
        report_t r;
        mag = isqrt(square_axis(s.x) + square_axis(s.y) + square_axis(s.z));
        if (ring_cnt >= WINDOW_DEPTH)
            win_sum -= ring[ring_ptr];
        else
            ring_cnt++;
        ring[ring_ptr] = mag;
        win_sum += mag;
        ring_ptr = (ring_ptr + 1) % WINDOW_DEPTH;
        if (mag < min_mag) min_mag = mag;
        if (mag > max_mag) max_mag = mag;
        // arm crossing, then count crossing against the updated level
        if (mag > p_high && latch_lvl < p_high)
        begin
            swing_val = mag - latch_lvl;
            latch_lvl = mag;
        end
        if (mag < p_low && 17'(latch_lvl) > 17'(p_low) + 17'(p_margin))
        begin
            if (steps != 16'hFFFF) steps++;
            swing_val = latch_lvl - mag;
            latch_lvl = mag;
        end
        if (sample_cnt == 0)
        begin
            r.magnitude = mag;
            r.ax = s.x; r.ay = s.y; r.az = s.z;
            r.steps = steps; r.mn = min_mag; r.mx = max_mag; r.swing = swing_val;
            r.mean = 16'(win_sum / ring_cnt);
            expected_reports.push_back(r);
            steps = 0;
        end
        if (sample_cnt == p_period) sample_cnt = 0;
        else sample_cnt = sample_cnt + 1'b1;
    endtask

    // driver: offer queued samples, idle in bursts
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (s_in.valid && s_in.ready)
        begin
            predict_sample(sample_t'{s_in.mag_x, s_in.mag_y, s_in.mag_z});
            sent++;
        end
        if (!(s_in.valid && !s_in.ready))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                s_in.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0 && (no_idle || $urandom_range(0, 9) != 0))
            begin
                sample_t s;
                s = pending_samples.pop_front();
                s_in.valid <= 1'b1;
                s_in.mag_x <= s.x; s_in.mag_y <= s.y; s_in.mag_z <= s.z;
            end
            else
            begin
                s_in.valid <= 1'b0;
                if (!no_idle && pending_samples.size() > 0) in_gap <= $urandom_range(0, 16);
            end
        end
    end

    // monitor: random ready with bursts of stall, compare each report beat
    int out_gap = 0;
    always @(posedge clk)
    begin
        if (s_out.valid && s_out.ready)
        begin
            report_t got, exp;
            got = report_t'{s_out.magnitude, s_out.axis_x, s_out.axis_y, s_out.axis_z,
                            s_out.step_count, s_out.min_magnitude, s_out.max_magnitude,
                            s_out.last_swing, s_out.mean_magnitude};
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp = expected_reports.pop_front();
                if (got !== exp)
                begin
                    $display("%0t: report mismatch, expected %h, actual %h", $time, exp, got);
                    errors++;
                end
            end
        end
        if (hold_off)
            s_out.ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            s_out.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 11) == 0)
        begin
            out_gap <= $urandom_range(0, 16);
            s_out.ready <= 1'b0;
        end
        else
            s_out.ready <= 1'b1;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_HIGH: p_high = val[15:0];
            REG_LOW: p_low = val[15:0];
            REG_MARGIN: p_margin = val[15:0];
            default: p_period = val[15:0];
        endcase
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !s_in.valid);
        wait (expected_reports.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // pulse train: rise above high then fall below low, with random content
    task automatic queue_pulses(int n);
        for (int i = 0; i < n; i++)
        begin
            int kind;
            kind = $urandom_range(0, 9);
            if (kind < 4)
                pending_samples.push_back(sample_t'{16'(p_high + $urandom_range(1, 3000)),
                                                    16'(0), 16'(0)});
            else if (kind < 8 && p_low > 0)
                pending_samples.push_back(sample_t'{16'(0), 16'($urandom_range(0, p_low - 1)),
                                                    16'(0)});
            else
                pending_samples.push_back(sample_t'{rand_axis(), rand_axis(), rand_axis()});
        end
    endtask

    initial
    begin
        s_in.valid = 1'b0; s_in.mag_x = '0; s_in.mag_y = '0; s_in.mag_z = '0;
        s_out.ready = 1'b0;
        p_high = 17000; p_low = 3000; p_margin = 500; p_period = 79;
        latch_lvl = 0; min_mag = 16'hFFFF; max_mag = 0; swing_val = 0; steps = 0;
        sample_cnt = 0; ring_ptr = 0; ring_cnt = 0; win_sum = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: report every sample, field extremes and both crossings
        reg_write(REG_PERIOD, 32'hFFFF_0000);
        pending_samples.push_back(sample_t'{16'sh0000, 16'sh0000, 16'sh0000});
        pending_samples.push_back(sample_t'{16'sh8000, 16'sh8000, 16'sh8000});
        pending_samples.push_back(sample_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_samples.push_back(sample_t'{16'sh0000, 16'sh0001, 16'sh0000});
        pending_samples.push_back(sample_t'{16'sh5000, 16'shB000, 16'sh1234});
        pending_samples.push_back(sample_t'{16'sh0010, 16'sh0000, 16'sh0000});
        pending_samples.push_back(sample_t'{16'sh4E20, 16'sh0000, 16'sh0000});
        pending_samples.push_back(sample_t'{16'sh0000, 16'sh0000, 16'shFF00});
        pending_samples.push_back(sample_t'{16'shFFFF, 16'sh0001, 16'shFFFF});
        drain();

        // zero margin and thresholds at the extremes
        reg_write(REG_MARGIN, 0);
        reg_write(REG_HIGH, 65535);
        reg_write(REG_LOW, 0);
        queue_pulses(10);
        drain();
        reg_write(REG_HIGH, 0);
        reg_write(REG_LOW, 65535);
        reg_write(REG_MARGIN, 65535);
        queue_pulses(10);
        drain();

        // typical pulse counting, long receiver hold-off to fill the block
        reg_write(REG_HIGH, 17000);
        reg_write(REG_LOW, 3000);
        reg_write(REG_MARGIN, 500);
        reg_write(REG_PERIOD, 2);
        hold_off = 1'b1;
        queue_pulses(42);
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
        drain();

        // report every sample, then every eighth and every fourth
        reg_write(REG_PERIOD, 0);
        queue_pulses(300);
        drain();
        reg_write(REG_PERIOD, 7);
        reg_write(REG_MARGIN, $urandom_range(0, 2000));
        queue_pulses(400);
        drain();
        reg_write(REG_PERIOD, 3);
        reg_write(REG_HIGH, $urandom_range(5000, 40000));
        reg_write(REG_LOW, $urandom_range(100, 5000));
        no_idle = 1'b1;
        queue_pulses(500);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
